>>> rtl/ucd_pkg.sv
// ----------------------------------------------------------------------------
// ucd_pkg
// Shared types and constants for the USB configuration descriptor parser:
// payload structs, record kinds, device modes and class flag bit positions.
// ----------------------------------------------------------------------------
package ucd_pkg;

   // descriptor layout
   localparam int unsigned HDR_LEN     = 9;
   localparam logic [7:0]  TYPE_IFACE  = 8'h04;
   localparam logic [7:0]  TYPE_EP     = 8'h05;
   localparam logic [7:0]  IFACE_MIN   = 8'd9;
   localparam logic [7:0]  EP_MIN      = 8'd7;
   localparam logic [7:0]  REC_MIN     = 8'd3;

   // interface class codes
   localparam logic [7:0] CLS_VENDOR  = 8'hFF;
   localparam logic [7:0] CLS_CDC     = 8'h02;
   localparam logic [7:0] CLS_MISC    = 8'hEF;
   localparam logic [7:0] CLS_HID     = 8'h03;
   localparam logic [7:0] CLS_AUDIO   = 8'h01;
   localparam logic [7:0] CLS_VIDEO   = 8'h0E;
   localparam logic [7:0] SUB_ADB     = 8'h42;
   localparam logic [7:0] SUB_MTP     = 8'hFF;
   localparam logic [7:0] SUB_ACM     = 8'h02;
   localparam logic [7:0] SUB_RNDIS   = 8'h04;
   localparam logic [7:0] PRO_ADB     = 8'h01;
   localparam logic [7:0] PRO_SIDE    = 8'h02;
   localparam logic [7:0] PRO_FBOOT   = 8'h03;
   localparam logic [7:0] PRO_RNDIS   = 8'h01;

   // class flag bit positions
   localparam int unsigned FLG_ADB   = 0;
   localparam int unsigned FLG_SIDE  = 1;
   localparam int unsigned FLG_FBOOT = 2;
   localparam int unsigned FLG_MTP   = 3;
   localparam int unsigned FLG_RNDIS = 4;
   localparam int unsigned FLG_HID   = 5;
   localparam int unsigned FLG_AUDIO = 6;
   localparam int unsigned FLG_VIDEO = 7;

   typedef enum logic [1:0] {
      KIND_IFACE   = 2'd0,
      KIND_EP      = 2'd1,
      KIND_SUMMARY = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      MODE_FASTBOOT = 3'd0,
      MODE_RECOVERY = 3'd1,
      MODE_ADB      = 3'd2,
      MODE_MTP      = 3'd3,
      MODE_RNDIS    = 3'd4,
      MODE_HID      = 3'd5,
      MODE_CHARGING = 3'd6
   } mode_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  record_kind;
      logic [7:0]  number_or_address;
      logic [7:0]  alt_or_attributes;
      logic [7:0]  class_code;
      logic [7:0]  subclass_code;
      logic [7:0]  protocol_code;
      logic [7:0]  endpoint_total;
      logic [15:0] max_packet_size;
      logic [7:0]  poll_interval;
      logic [7:0]  class_flags;
      logic [3:0]  interface_total;
      logic [2:0]  device_mode;
   } rsp_type;

   // parser to queue: up to two results per accepted byte
   typedef struct packed {
      logic    rec_valid;
      rsp_type rec;
      logic    sum_valid;
      rsp_type sum;
   } push_type;

endpackage

>>> rtl/ucd_parse.sv
// ----------------------------------------------------------------------------
// ucd_parse
// Byte-wise descriptor walker. Holds the header and record position state,
// captures record bytes and produces the interface, endpoint and summary
// results caused by each accepted byte in the same cycle.
// ----------------------------------------------------------------------------
module ucd_parse import ucd_pkg::*; #(
   parameter int MAX_INTERFACES = 8,
   parameter int MAX_ENDPOINTS  = 16
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     accept,
   input  req_type  req,
   output push_type push
);

   localparam int IfW = $clog2(MAX_INTERFACES + 1);
   localparam int EpW = $clog2(MAX_ENDPOINTS + 1);

   logic [3:0]     hdr_pos_ff,   hdr_pos_in;
   logic [15:0]    total_len_ff, total_len_in;
   logic [15:0]    remain_ff,    remain_in;
   logic [7:0]     rec_pos_ff,   rec_pos_in;
   logic [7:0]     rec_len_ff,   rec_len_in;
   logic [7:0]     rec_type_ff,  rec_type_in;
   logic [47:0]    cap_ff,       cap_in;
   logic [IfW-1:0] if_cnt_ff,    if_cnt_in;
   logic [EpW-1:0] ep_cnt_ff,    ep_cnt_in;
   logic           stopped_ff,   stopped_in;
   logic [7:0]     flags_ff,     flags_in;

   logic [7:0]  b;
   logic [7:0]  pos_inc;
   logic        finish;
   logic [7:0]  cls, sub, pro;
   mode_type    mode;
   rsp_type     rec;
   rsp_type     sum;
   logic        rec_valid;

   assign b = req.data_byte;

   // next state and record results
   always_comb begin
      hdr_pos_in   = hdr_pos_ff;
      total_len_in = total_len_ff;
      remain_in    = remain_ff;
      rec_pos_in   = rec_pos_ff;
      rec_len_in   = rec_len_ff;
      rec_type_in  = rec_type_ff;
      cap_in       = cap_ff;
      if_cnt_in    = if_cnt_ff;
      ep_cnt_in    = ep_cnt_ff;
      stopped_in   = stopped_ff;
      flags_in     = flags_ff;
      pos_inc      = rec_pos_ff + 8'd1;
      finish       = 1'b0;
      rec_valid    = 1'b0;
      rec          = '0;
      cls          = '0;
      sub          = '0;
      pro          = '0;

      if (32'(hdr_pos_ff) < HDR_LEN) begin
         // configuration header, pick up wTotalLength
         if (hdr_pos_ff == 4'd2) total_len_in[7:0]  = b;
         if (hdr_pos_ff == 4'd3) total_len_in[15:8] = b;
         hdr_pos_in = hdr_pos_ff + 4'd1;
         if (32'(hdr_pos_in) == HDR_LEN) begin
            remain_in = (32'(total_len_in) >= HDR_LEN) ?
                        total_len_in - 16'(HDR_LEN) : 16'd0;
         end
      end else if (!stopped_ff) begin
         if (rec_pos_ff == 8'd0) begin
            // record length byte
            if (remain_ff < 16'(REC_MIN) || 32'(if_cnt_ff) >= MAX_INTERFACES ||
                b < REC_MIN || 16'(b) > remain_ff) begin
               stopped_in = 1'b1;
            end else begin
               rec_len_in  = b;
               rec_type_in = '0;
               cap_in      = '0;
               rec_pos_in  = 8'd1;
            end
         end else begin
            // record body
            if (rec_pos_ff == 8'd1) begin
               rec_type_in = b;
            end else if (rec_pos_ff <= 8'd7) begin
               cap_in[(rec_pos_ff[2:0] - 3'd2) * 8 +: 8] = b;
            end
            rec_pos_in = pos_inc;
            if (pos_inc >= rec_len_ff) begin
               finish     = 1'b1;
               remain_in  = remain_ff - 16'(rec_len_ff);
               rec_pos_in = 8'd0;
            end
         end
      end

      // completed record
      if (finish) begin
         cls = cap_in[31:24];
         sub = cap_in[39:32];
         pro = cap_in[47:40];
         if (rec_type_ff == TYPE_IFACE && rec_len_ff >= IFACE_MIN) begin
            rec_valid             = 1'b1;
            rec.record_kind       = KIND_IFACE;
            rec.number_or_address = cap_in[7:0];
            rec.alt_or_attributes = cap_in[15:8];
            rec.class_code        = cls;
            rec.subclass_code     = sub;
            rec.protocol_code     = pro;
            rec.endpoint_total    = cap_in[23:16];
            if_cnt_in             = if_cnt_ff + IfW'(1);
            ep_cnt_in             = '0;
            if (cls == CLS_VENDOR && sub == SUB_ADB) begin
               if (pro == PRO_ADB)   flags_in[FLG_ADB]   = 1'b1;
               if (pro == PRO_SIDE)  flags_in[FLG_SIDE]  = 1'b1;
               if (pro == PRO_FBOOT) flags_in[FLG_FBOOT] = 1'b1;
            end
            if (cls == CLS_VENDOR && sub == SUB_MTP) flags_in[FLG_MTP] = 1'b1;
            if (cls == CLS_CDC && sub == SUB_ACM && pro == PRO_RNDIS)
               flags_in[FLG_RNDIS] = 1'b1;
            if (cls == CLS_MISC && sub == SUB_RNDIS && pro == PRO_RNDIS)
               flags_in[FLG_RNDIS] = 1'b1;
            if (cls == CLS_HID)   flags_in[FLG_HID]   = 1'b1;
            if (cls == CLS_AUDIO) flags_in[FLG_AUDIO] = 1'b1;
            if (cls == CLS_VIDEO) flags_in[FLG_VIDEO] = 1'b1;
         end else if (rec_type_ff == TYPE_EP && rec_len_ff >= EP_MIN &&
                      if_cnt_ff != '0 && 32'(ep_cnt_ff) < MAX_ENDPOINTS) begin
            rec_valid             = 1'b1;
            rec.record_kind       = KIND_EP;
            rec.number_or_address = cap_in[7:0];
            rec.alt_or_attributes = cap_in[15:8];
            rec.max_packet_size   = cap_in[31:16];
            rec.poll_interval     = cap_in[39:32];
            ep_cnt_in             = ep_cnt_ff + EpW'(1);
         end
      end
   end

   // device mode from the updated flags
   always_comb begin
      if (flags_in[FLG_FBOOT]) begin
         mode = MODE_FASTBOOT;
      end else if (flags_in[FLG_ADB] && flags_in[FLG_SIDE]) begin
         mode = MODE_RECOVERY;
      end else if (flags_in[FLG_ADB]) begin
         mode = (32'(if_cnt_in) <= 32'd2) ? MODE_RECOVERY : MODE_ADB;
      end else if (flags_in[FLG_MTP]) begin
         mode = MODE_MTP;
      end else if (flags_in[FLG_RNDIS]) begin
         mode = MODE_RNDIS;
      end else if (flags_in[FLG_HID]) begin
         mode = MODE_HID;
      end else begin
         mode = MODE_CHARGING;
      end
   end

   // summary result
   always_comb begin
      sum                 = '0;
      sum.record_kind     = KIND_SUMMARY;
      sum.class_flags     = flags_in;
      sum.interface_total = 4'(32'(if_cnt_in));
      sum.device_mode     = mode;
   end

   assign push.rec_valid = accept && rec_valid;
   assign push.rec       = rec;
   assign push.sum_valid = accept && req.last_byte;
   assign push.sum       = sum;

   // state registers, cleared after the last byte
   always_ff @(posedge clock) begin
      if (reset || (accept && req.last_byte)) begin
         hdr_pos_ff   <= '0;
         total_len_ff <= '0;
         remain_ff    <= '0;
         rec_pos_ff   <= '0;
         rec_len_ff   <= '0;
         rec_type_ff  <= '0;
         cap_ff       <= '0;
         if_cnt_ff    <= '0;
         ep_cnt_ff    <= '0;
         stopped_ff   <= 1'b0;
         flags_ff     <= '0;
      end else if (accept) begin
         hdr_pos_ff   <= hdr_pos_in;
         total_len_ff <= total_len_in;
         remain_ff    <= remain_in;
         rec_pos_ff   <= rec_pos_in;
         rec_len_ff   <= rec_len_in;
         rec_type_ff  <= rec_type_in;
         cap_ff       <= cap_in;
         if_cnt_ff    <= if_cnt_in;
         ep_cnt_ff    <= ep_cnt_in;
         stopped_ff   <= stopped_in;
         flags_ff     <= flags_in;
      end
   end

   // a walk only stops once the header is through
   a_stop_after_hdr: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |-> 32'(hdr_pos_ff) == HDR_LEN)
      else $error("walk stopped inside header");

   // an open record never reaches its length
   a_rec_pos: assert property (@(posedge clock) disable iff (reset)
      rec_pos_ff != 8'd0 |-> rec_pos_ff < rec_len_ff)
      else $error("record position past record length");

   // the last byte returns the walker to its start
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req.last_byte |=> hdr_pos_ff == 4'd0 && flags_ff == 8'd0 &&
                                   if_cnt_ff == '0)
      else $error("state not cleared after last byte");

   // interface count never passes its limit
   a_if_limit: assert property (@(posedge clock) disable iff (reset)
      32'(if_cnt_ff) <= MAX_INTERFACES)
      else $error("interface count beyond limit");

endmodule

>>> rtl/ucd_out_queue.sv
// ----------------------------------------------------------------------------
// ucd_out_queue
// Four-entry result queue. Takes up to two results per cycle from the parser
// and hands them out one beat at a time; asks for a stall when fewer than two
// entries are free.
// ----------------------------------------------------------------------------
module ucd_out_queue import ucd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     full,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   localparam int Depth = 4;

   rsp_type    entry_ff [Depth];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] cnt_ff,    cnt_in;
   logic       pop;
   logic [1:0] push_n;
   logic [1:0] sum_slot;

   assign rsp_valid = cnt_ff != 3'd0;
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;
   assign full      = cnt_ff > 3'd2;

   // pointer and count update
   always_comb begin
      push_n    = 2'(push.rec_valid) + 2'(push.sum_valid);
      sum_slot  = push.rec_valid ? wr_ptr_ff + 2'd1 : wr_ptr_ff;
      wr_ptr_in = wr_ptr_ff + push_n;
      rd_ptr_in = rd_ptr_ff + 2'(pop);
      cnt_in    = cnt_ff + 3'(push_n) - 3'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push.rec_valid) entry_ff[wr_ptr_ff] <= push.rec;
      if (push.sum_valid) entry_ff[sum_slot]  <= push.sum;
   end

   // never more entries than storage
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'(Depth))
      else $error("result queue overflow");

   // pushes only arrive while there is room for two
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push.rec_valid || push.sum_valid |-> !full)
      else $error("push while queue full");

   // count tracks the pointer distance
   a_cnt_ptr: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 3'(Depth) |-> 2'(cnt_ff) == 2'(wr_ptr_ff - rd_ptr_ff))
      else $error("queue count and pointers disagree");

endmodule

>>> rtl/usb_config_descriptor_parser.sv
// ----------------------------------------------------------------------------
// usb_config_descriptor_parser
// Walks a USB configuration descriptor one byte per beat and reports its
// interface and endpoint records plus a summary on the last byte.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one descriptor byte per beat, with last_byte marking the
//   final byte. rsp_* carries interface records, endpoint records and one
//   summary (class flags, interface count, device mode) per descriptor.
//   A beat moves on a rising edge with valid high and stall low.
// Flow:
//   a result caused by a byte enters the result queue as the byte is taken
//   and is offered on rsp_* once all earlier results have left. One byte is
//   taken per cycle while req_stall is low; a byte that completes a record
//   and is also the last byte yields two results, which leave one after the
//   other via the four-entry result queue. req_stall rises while fewer than
//   two entries are free, so a stalled receiver holds input back at three results.
// Reset:
//   synchronous reset clears the walker state and empties the queue; the
//   walker also returns to its start after every last byte.
// ----------------------------------------------------------------------------
module usb_config_descriptor_parser import ucd_pkg::*; #(
   parameter int MAX_INTERFACES = 8,
   parameter int MAX_ENDPOINTS  = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic     accept;
   logic     full;
   push_type push;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   // byte walker
   ucd_parse #(
      .MAX_INTERFACES (MAX_INTERFACES),
      .MAX_ENDPOINTS  (MAX_ENDPOINTS)
   ) u_parse (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .push   (push)
   );

   // result queue
   ucd_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
